### sv/shsp_pkg.sv
// Shared types and constants for the scene hierarchy stack parser.
// No dependencies. Used by shsp_stack_cell and scene_hierarchy_stack_parser.
package shsp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int MAX_NODES   = 65536;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int NODE_W      = $clog2(MAX_NODES + 1);
    localparam int ENTRY_CNT_W = 30;

    // raw entry type codes
    localparam logic [15:0] TYPE_END      = 16'h0000;
    localparam logic [15:0] TYPE_OPEN     = 16'h0001;
    localparam logic [15:0] TYPE_CLOSE    = 16'h0002;
    localparam logic [15:0] TYPE_JOINT    = 16'h0010;
    localparam logic [15:0] TYPE_MATERIAL = 16'h0011;
    localparam logic [15:0] TYPE_SHAPE    = 16'h0012;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_UNKNOWN       = 3'd1,
        ST_OPEN_NO_JOINT = 3'd2,
        ST_CLOSE_EMPTY   = 3'd3,
        ST_END_UNCLOSED  = 3'd4,
        ST_NO_END        = 3'd5,
        ST_STACK_OVF     = 3'd6,
        ST_NODE_OVF      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        KIND_END      = 3'd0,
        KIND_OPEN     = 3'd1,
        KIND_CLOSE    = 3'd2,
        KIND_JOINT    = 3'd3,
        KIND_MATERIAL = 3'd4,
        KIND_SHAPE    = 3'd5
    } t_kind;

    // per-cycle shift command for the stack cell row
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic        node_made;
        logic [15:0] node_number;
        logic [15:0] node_ref;
        logic        has_parent;
        logic [15:0] parent_number;
        logic [31:0] entry_offset;
        logic        finished;
    } t_result;

endpackage

### sv/shsp_stack_cell.sv
// One slot of the shifting joint stack: loads from the cell above on push,
// from the cell below on pop. Depends on shsp_pkg.
module shsp_stack_cell
    import shsp_pkg::*;
(
    input  logic        i_clk,
    input  t_stack_ctl  i_ctl,
    input  logic [15:0] i_from_up,
    input  logic [15:0] i_from_down,
    output logic [15:0] o_value
);

    logic [15:0] r_value;
    logic [15:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            n_value = i_from_up;
        end else if (i_ctl.pop) begin
            n_value = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### sv/scene_hierarchy_stack_parser.sv
// Top level of the scene hierarchy stack parser: entry decode, hierarchy
// state, output register with skid. Depends on shsp_pkg and shsp_stack_cell.
//
// Usage:
//   Input channel (i_valid / o_stall): one 4-byte hierarchy entry per
//   transaction (type code, entry index, last-entry flag).
//   Output channel (o_valid / i_stall): one result transaction per entry,
//   in order: status, decoded kind, node fields, entry offset, finished.
//   Config channel (i_cfg_valid / o_cfg_ready): writes hierarchy_base; ready
//   is always high. Write only while the block is idle.
// Result: registered in the output register, or in the skid slot while that is held.
// Throughput: one entry per cycle while o_stall is low. Each entry only reads
//   the stack top (cell 0 of the shifting cell row) and shifts the row one
//   place.
// Stall: a two-deep output (output register plus skid) lets one more entry
//   be accepted while a result waits; o_stall rises only when both are full.
// Reset: clears the hierarchy state, hierarchy_base and both output valid flags.
//   Stack cells hold no reset; only slots below the depth counter are read.
// After End or any error the hierarchy state clears; hierarchy_base stays.
module scene_hierarchy_stack_parser
    import shsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // entry channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_type,
    input  logic [15:0] i_entry_index,
    input  logic        i_last_entry,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_entry_kind,
    output logic        o_node_made,
    output logic [15:0] o_node_number,
    output logic [15:0] o_node_ref,
    output logic        o_has_parent,
    output logic [15:0] o_parent_number,
    output logic [31:0] o_entry_offset,
    output logic        o_finished,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // hierarchy state
    logic [31:0]            r_base;
    logic [DEPTH_W-1:0]     r_depth,       n_depth;
    logic [NODE_W-1:0]      r_node_count,  n_node_count;
    logic                   r_joint_valid, n_joint_valid;
    logic [15:0]            r_joint_num,   n_joint_num;
    logic [ENTRY_CNT_W-1:0] r_entry_count, n_entry_count;

    // output register and skid slot
    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;

    t_result    w_res;
    t_stack_ctl w_ctl;
    logic       w_acc_in;
    logic       w_acc_out;
    logic       w_unknown;
    logic [15:0] w_cell_q [STACK_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign w_acc_in    = i_valid & ~r_skid_valid;
    assign w_acc_out   = r_out_valid & ~i_stall;

    // ---- entry decode and result ----
    always_comb begin
        w_res             = '0;
        w_res.status      = ST_OK;
        w_res.kind        = KIND_END;
        w_unknown         = 1'b0;
        // entry offset: base + 4 * entry count, wrapping at 32 bits
        w_res.entry_offset = r_base + {r_entry_count, 2'b00};
        case (i_raw_type)
            TYPE_END:      w_res.kind = KIND_END;
            TYPE_OPEN:     w_res.kind = KIND_OPEN;
            TYPE_CLOSE:    w_res.kind = KIND_CLOSE;
            TYPE_JOINT:    w_res.kind = KIND_JOINT;
            TYPE_MATERIAL: w_res.kind = KIND_MATERIAL;
            TYPE_SHAPE:    w_res.kind = KIND_SHAPE;
            default:       w_unknown  = 1'b1;
        endcase

        if (w_unknown) begin
            w_res.status = ST_UNKNOWN;
        end else begin
            case (w_res.kind)
                KIND_END: begin
                    if (r_depth != '0) begin
                        w_res.status = ST_END_UNCLOSED;
                    end
                end
                KIND_OPEN: begin
                    if (!r_joint_valid) begin
                        w_res.status = ST_OPEN_NO_JOINT;
                    end else if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                        w_res.status = ST_STACK_OVF;
                    end
                end
                KIND_CLOSE: begin
                    if (r_depth == '0) begin
                        w_res.status = ST_CLOSE_EMPTY;
                    end
                end
                default: begin
                    // joint, material, shape: make a node
                    if (r_node_count >= NODE_W'(MAX_NODES)) begin
                        w_res.status = ST_NODE_OVF;
                    end else begin
                        w_res.node_made   = 1'b1;
                        w_res.node_number = 16'(r_node_count);
                        w_res.node_ref    = i_entry_index;
                        if (r_depth != '0) begin
                            w_res.has_parent    = 1'b1;
                            w_res.parent_number = w_cell_q[0];
                        end
                    end
                end
            endcase
            // missing End only when the entry itself is clean
            if (w_res.status == ST_OK && w_res.kind != KIND_END && i_last_entry) begin
                w_res.status = ST_NO_END;
            end
        end
        w_res.finished = (w_res.status != ST_OK) || (w_res.kind == KIND_END);
    end

    // ---- stack shift command ----
    always_comb begin
        w_ctl      = '0;
        w_ctl.push = w_acc_in && !w_unknown && w_res.kind == KIND_OPEN &&
                     r_joint_valid && (r_depth != DEPTH_W'(STACK_DEPTH));
        w_ctl.pop  = w_acc_in && !w_unknown && w_res.kind == KIND_CLOSE &&
                     (r_depth != '0);
    end

    // ---- stack cell row: cell 0 is the top ----
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [15:0] w_up;
        logic [15:0] w_down;
        if (g == 0) begin : g_top
            assign w_up = r_joint_num;
        end else begin : g_mid
            assign w_up = w_cell_q[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_down = w_cell_q[g];
        end else begin : g_nbot
            assign w_down = w_cell_q[g+1];
        end
        shsp_stack_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_value     (w_cell_q[g])
        );
    end

    // ---- hierarchy state next values ----
    always_comb begin
        n_depth       = r_depth;
        n_node_count  = r_node_count;
        n_joint_valid = r_joint_valid;
        n_joint_num   = r_joint_num;
        n_entry_count = r_entry_count;
        if (w_acc_in) begin
            if (w_res.finished) begin
                n_depth       = '0;
                n_node_count  = '0;
                n_joint_valid = 1'b0;
                n_joint_num   = '0;
                n_entry_count = '0;
            end else begin
                n_entry_count = r_entry_count + 1'b1;
                if (w_ctl.push) begin
                    n_depth = r_depth + 1'b1;
                end else if (w_ctl.pop) begin
                    n_depth = r_depth - 1'b1;
                end
                if (w_res.node_made) begin
                    n_node_count = r_node_count + 1'b1;
                    if (w_res.kind == KIND_JOINT) begin
                        n_joint_valid = 1'b1;
                        n_joint_num   = w_res.node_number;
                    end
                end
            end
        end
    end

    // ---- output register and skid ----
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_acc_out || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_res;
                n_out_valid = w_acc_in;
            end
        end else if (w_acc_in) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= '0;
            r_depth       <= '0;
            r_node_count  <= '0;
            r_joint_valid <= 1'b0;
            r_joint_num   <= '0;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            r_depth       <= n_depth;
            r_node_count  <= n_node_count;
            r_joint_valid <= n_joint_valid;
            r_joint_num   <= n_joint_num;
            r_entry_count <= n_entry_count;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_entry_kind    = r_out.kind;
    assign o_node_made     = r_out.node_made;
    assign o_node_number   = r_out.node_number;
    assign o_node_ref      = r_out.node_ref;
    assign o_has_parent    = r_out.has_parent;
    assign o_parent_number = r_out.parent_number;
    assign o_entry_offset  = r_out.entry_offset;
    assign o_finished      = r_out.finished;

    // ---- assertions ----
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth above capacity");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with empty output register");

    a_clear_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && w_res.finished) |=>
            (r_depth == '0 && r_node_count == '0 && !r_joint_valid))
        else $error("hierarchy state not cleared after finish");

    a_node_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_node_made) |->
            (o_status == ST_OK || o_status == ST_NO_END))
        else $error("node reported with entry error");

endmodule

### dv/tb_scene_hierarchy_stack_parser.sv
// Self-checking testbench for scene_hierarchy_stack_parser: directed and random
// hierarchy streams, predicted results compared field by field in order.
// Depends on shsp_pkg and the parser RTL only.
module tb_scene_hierarchy_stack_parser
    import shsp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: tracks the hierarchy state of the parser and queues the
    // result each accepted entry should produce.
    class hier_scoreboard;
        logic [31:0] base;
        logic [15:0] open_joints [STACK_DEPTH];
        int unsigned depth;
        int unsigned nodes;
        bit          joint_seen;
        logic [15:0] joint_num;
        logic [29:0] entries;
        t_result     expected_q [$];
        int          checked;
        int          errors;

        function new();
            base       = '0;
            depth      = 0;
            nodes      = 0;
            joint_seen = 1'b0;
            joint_num  = '0;
            entries    = '0;
            checked    = 0;
            errors     = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // predict the result of one accepted entry and advance the state
        function void note_entry(logic [15:0] raw, logic [15:0] idx, logic last);
            t_result r;
            bit      done;
            r              = '0;
            done           = 1'b0;
            r.status       = ST_OK;
            r.entry_offset = base + {entries, 2'b00};
            case (raw)
                TYPE_END:      r.kind = KIND_END;
                TYPE_OPEN:     r.kind = KIND_OPEN;
                TYPE_CLOSE:    r.kind = KIND_CLOSE;
                TYPE_JOINT:    r.kind = KIND_JOINT;
                TYPE_MATERIAL: r.kind = KIND_MATERIAL;
                TYPE_SHAPE:    r.kind = KIND_SHAPE;
                default: begin
                    r.status = ST_UNKNOWN;
                    r.kind   = KIND_END;
                end
            endcase
            if (r.status == ST_OK) begin
                case (r.kind)
                    KIND_END: begin
                        if (depth != 0)
                            r.status = ST_END_UNCLOSED;
                        else
                            done = 1'b1;
                    end
                    KIND_OPEN: begin
                        if (!joint_seen) begin
                            r.status = ST_OPEN_NO_JOINT;
                        end else if (depth >= STACK_DEPTH) begin
                            r.status = ST_STACK_OVF;
                        end else begin
                            open_joints[depth] = joint_num;
                            depth++;
                        end
                    end
                    KIND_CLOSE: begin
                        if (depth == 0)
                            r.status = ST_CLOSE_EMPTY;
                        else
                            depth--;
                    end
                    default: begin
                        if (nodes >= MAX_NODES) begin
                            r.status = ST_NODE_OVF;
                        end else begin
                            r.node_made   = 1'b1;
                            r.node_number = nodes[15:0];
                            r.node_ref    = idx;
                            if (depth > 0) begin
                                r.has_parent    = 1'b1;
                                r.parent_number = open_joints[depth - 1];
                            end
                            if (r.kind == KIND_JOINT) begin
                                joint_seen = 1'b1;
                                joint_num  = nodes[15:0];
                            end
                            nodes++;
                        end
                    end
                endcase
                // section ran out before End; own errors take precedence
                if (r.status == ST_OK && r.kind != KIND_END && last)
                    r.status = ST_NO_END;
            end
            if (r.status != ST_OK)
                done = 1'b1;
            r.finished = done;
            if (done) begin
                depth      = 0;
                nodes      = 0;
                joint_seen = 1'b0;
                joint_num  = '0;
                entries    = '0;
            end else begin
                entries++;
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            // keep the log short when the block is badly broken
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h expected 0x%0h",
                                          checked, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_q.pop_front();
            check_field("status",        32'(got.status),        32'(want.status));
            check_field("entry_kind",    32'(got.kind),          32'(want.kind));
            check_field("node_made",     32'(got.node_made),     32'(want.node_made));
            check_field("node_number",   32'(got.node_number),   32'(want.node_number));
            check_field("node_ref",      32'(got.node_ref),      32'(want.node_ref));
            check_field("has_parent",    32'(got.has_parent),    32'(want.has_parent));
            check_field("parent_number", 32'(got.parent_number), 32'(want.parent_number));
            check_field("entry_offset",  got.entry_offset,       want.entry_offset);
            check_field("finished",      32'(got.finished),      32'(want.finished));
        endtask
    endclass

    // DUT signals; every input starts at a known value
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [15:0] i_raw_type    = '0;
    logic [15:0] i_entry_index = '0;
    logic        i_last_entry  = 1'b0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_entry_kind;
    logic        o_node_made;
    logic [15:0] o_node_number;
    logic [15:0] o_node_ref;
    logic        o_has_parent;
    logic [15:0] o_parent_number;
    logic [31:0] o_entry_offset;
    logic        o_finished;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = '0;

    hier_scoreboard sb;
    t_result        out_item;

    // idle shaping: sender gaps between bursts, receiver stall pattern
    int burst_left = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int stall_max  = 0;
    int stall_hold = 0;
    int sent       = 0;

    scene_hierarchy_stack_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_type     (i_raw_type),
        .i_entry_index  (i_entry_index),
        .i_last_entry   (i_last_entry),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entry_kind   (o_entry_kind),
        .o_node_made    (o_node_made),
        .o_node_number  (o_node_number),
        .o_node_ref     (o_node_ref),
        .o_has_parent   (o_has_parent),
        .o_parent_number(o_parent_number),
        .o_entry_offset (o_entry_offset),
        .o_finished     (o_finished),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side. Outputs read here are the values from before the edge,
    // so a transaction is taken exactly when the DUT sees it taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && !i_stall) begin
                out_item.status        = t_status'(o_status);
                out_item.kind          = t_kind'(o_entry_kind);
                out_item.node_made     = o_node_made;
                out_item.node_number   = o_node_number;
                out_item.node_ref      = o_node_ref;
                out_item.has_parent    = o_has_parent;
                out_item.parent_number = o_parent_number;
                out_item.entry_offset  = o_entry_offset;
                out_item.finished      = o_finished;
                sb.check_result(out_item);
            end
            // stall runs: start one at random, then hold it for a while
            if (stall_hold > 0) begin
                stall_hold--;
                i_stall <= 1'b1;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_hold = $urandom_range(0, stall_max);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Hard stop in case the run hangs.
    initial begin
        #1_000_000;
        $display("FAIL scene_hierarchy_stack_parser");
        $finish;
    end

    // 0: no idling, 1: light on both sides, 2: bursty sender, 3: slow receiver
    function void set_idle(int mode);
        case (mode)
            0: begin gap_max = 0; stall_pct = 0;  stall_max = 0;  end
            1: begin gap_max = 2; stall_pct = 15; stall_max = 2;  end
            2: begin gap_max = 8; stall_pct = 5;  stall_max = 1;  end
            default: begin gap_max = 1; stall_pct = 50; stall_max = 8; end
        endcase
    endfunction

    function logic [15:0] node_code(int k);
        case (k)
            0:       return TYPE_JOINT;
            1:       return TYPE_MATERIAL;
            default: return TYPE_SHAPE;
        endcase
    endfunction

    function logic [15:0] rand16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Offer one entry and hold it until the transaction completes.
    // Called just after the clock rises; valid stays high for the next entry.
    task automatic send_entry(input logic [15:0] raw, input logic [15:0] idx,
                              input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_raw_type    <= raw;
        i_entry_index <= idx;
        i_last_entry  <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_entry(raw, idx, last);
        sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // only while idle; ready is sampled at the edge like the data channels
    task automatic write_base(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.base = value;
        i_cfg_valid <= 1'b0;
    endtask

    // junk entry: any 16-bit code or a legal code out of place
    task automatic send_noise();
        logic [15:0] raw;
        case ($urandom_range(0, 7))
            0:       raw = TYPE_END;
            1:       raw = TYPE_OPEN;
            2:       raw = TYPE_CLOSE;
            3:       raw = node_code($urandom_range(0, 2));
            default: raw = rand16();
        endcase
        send_entry(raw, rand16(), $urandom_range(0, 3) == 0);
    endtask

    // A legal hierarchy with random content, now and then broken by a junk
    // entry or cut off by the end of the section.
    task automatic run_hierarchy(input int len);
        int k;
        int pick;
        int fault_at;
        fault_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
        for (k = 0; k < len; k++) begin
            if (k == fault_at)
                send_noise();
            pick = $urandom_range(0, 9);
            if (pick < 3 && sb.joint_seen && sb.depth < STACK_DEPTH)
                send_entry(TYPE_OPEN, rand16(), 1'b0);
            else if (pick < 5 && sb.depth > 0)
                send_entry(TYPE_CLOSE, rand16(), 1'b0);
            else
                send_entry(node_code($urandom_range(0, 2)), rand16(), 1'b0);
        end
        if ($urandom_range(0, 7) == 0) begin
            // section ends on a node, End never comes
            send_entry(node_code($urandom_range(0, 2)), rand16(), 1'b1);
        end else begin
            while (sb.depth > 0)
                send_entry(TYPE_CLOSE, rand16(), 1'b0);
            send_entry(TYPE_END, rand16(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int          k;
        int          random_start;
        int          last_cfg;
        logic [31:0] new_base;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: every kind, every status but stack and node overflow, field extremes ----
        set_idle(1);
        write_base(32'h0000_1000);
        send_entry(TYPE_JOINT,    16'h0000, 1'b0);   // root joint, node 0
        send_entry(TYPE_OPEN,     16'hFFFF, 1'b0);   // push node 0
        send_entry(TYPE_MATERIAL, 16'hFFFF, 1'b0);   // child of node 0
        send_entry(TYPE_JOINT,    16'h1234, 1'b0);   // node 2, child of 0
        send_entry(TYPE_OPEN,     16'h0000, 1'b0);   // push node 2
        send_entry(TYPE_SHAPE,    16'h8001, 1'b0);   // child of node 2
        send_entry(TYPE_CLOSE,    16'h0000, 1'b0);
        send_entry(TYPE_CLOSE,    16'h0000, 1'b0);
        send_entry(TYPE_END,      16'h0000, 1'b0);   // clean end
        send_entry(TYPE_CLOSE,    16'h0000, 1'b0);   // close on empty stack
        send_entry(TYPE_OPEN,     16'h0000, 1'b0);   // open before any joint
        send_entry(16'hFFFF,      16'hFFFF, 1'b1);   // unknown code, all ones
        send_entry(16'h0003,      16'h0000, 1'b0);   // unknown, next to legal codes
        send_entry(TYPE_JOINT,    16'h0007, 1'b0);
        send_entry(TYPE_OPEN,     16'h0000, 1'b0);
        send_entry(TYPE_END,      16'h0000, 1'b0);   // end with a joint still open
        send_entry(TYPE_SHAPE,    16'h00AA, 1'b1);   // node made, but no end
        send_entry(TYPE_END,      16'h0000, 1'b1);   // end on the last entry is fine
        send_entry(TYPE_JOINT,    16'h0055, 1'b0);
        send_entry(TYPE_OPEN,     16'h0000, 1'b1);   // open on last entry: no end
        send_entry(TYPE_CLOSE,    16'h0000, 1'b1);   // own error beats missing end
        settle();

        // ---- full stack: 32 nested joints, a leaf at the bottom, one open too many ----
        set_idle(3);
        write_base(32'hFFFF_FFFF);                     // offsets wrap at once
        for (k = 0; k < STACK_DEPTH; k++) begin
            send_entry(TYPE_JOINT, 16'(k), 1'b0);
            send_entry(TYPE_OPEN,  16'h0000, 1'b0);
        end
        send_entry(TYPE_SHAPE, 16'hBEEF, 1'b0);       // parent is the deepest joint
        send_entry(TYPE_OPEN,  16'h0000, 1'b0);       // stack overflow
        send_entry(TYPE_JOINT, 16'h0001, 1'b0);       // state cleared: root node 0
        send_entry(TYPE_END,   16'h0000, 1'b0);
        settle();

        // ---- random hierarchies, base changed now and then ----
        write_base($urandom);
        random_start = sent;
        last_cfg     = sent;
        while (sent - random_start < 560) begin
            set_idle($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else if ($urandom_range(0, 9) == 0)
                run_hierarchy($urandom_range(30, 90));
            else
                run_hierarchy($urandom_range(0, 20));
            if (sent - last_cfg >= 150) begin
                settle();
                case ($urandom_range(0, 3))
                    0:       new_base = 32'h0000_0000;
                    1:       new_base = 32'hFFFF_FFFF;
                    2:       new_base = 32'hFFFF_FFFC;
                    default: new_base = $urandom;
                endcase
                write_base(new_base);
                last_cfg = sent;
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("PASS scene_hierarchy_stack_parser");
        end else begin
            $display("FAIL scene_hierarchy_stack_parser");
        end
        $finish;
    end

endmodule
